>>> hw/rtl/escr_pkg.sv
package escr_pkg;

  localparam int TEMP_W  = 16;
  localparam int HUM_W   = 8;
  localparam int UV_W    = 29;
  localparam int UVM_W   = 9;
  localparam int PRESS_W = 16;
  localparam int PQ_W    = 11;
  localparam int RUN_W   = 8;
  localparam int FLAG_W  = 4;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [RUN_W-1:0] RUN_MAX = 8'd255;

  // op codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_EVAL = 1'b1;

  // pressure / 100 as multiply by reciprocal, exact for 17-bit inputs
  localparam logic [17:0] PRESS_RECIP = 18'd167773;
  localparam int          PRESS_SHIFT = 24;
  // (count * 7) / 1000 gives the uv value in millions, exact for 19-bit inputs
  localparam logic [19:0] UVM_RECIP   = 20'd536871;
  localparam int          UVM_SHIFT   = 29;
  localparam logic [12:0] UV_SCALE    = 13'd7000;

  localparam int FLAG_TEMP  = 0;
  localparam int FLAG_HUM   = 1;
  localparam int FLAG_UV    = 2;
  localparam int FLAG_PRESS = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TEMP_DEADBAND     = 3'd0,
    CFG_UV_DEADBAND       = 3'd1,
    CFG_TEMP_STABLE_NEED  = 3'd2,
    CFG_HUM_STABLE_NEED   = 3'd3,
    CFG_PRESS_STABLE_NEED = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [15:0]      temp_deadband;
    logic [8:0]       uv_deadband;
    logic [RUN_W-1:0] temp_stable_need;
    logic [RUN_W-1:0] hum_stable_need;
    logic [RUN_W-1:0] press_stable_need;
  } cfg_t;

  typedef struct packed {
    logic signed [TEMP_W-1:0] temperature;
    logic [HUM_W-1:0]         humidity;
    logic [UV_W-1:0]          uv;
    logic [UVM_W-1:0]         uv_millions;
    logic [PQ_W-1:0]          pressure;
  } sample_t;

  typedef struct packed {
    logic [FLAG_W-1:0]        flags;
    logic signed [TEMP_W-1:0] smp_temperature;
    logic [HUM_W-1:0]         smp_humidity;
    logic [UV_W-1:0]          smp_uv;
    logic [PRESS_W-1:0]       smp_pressure;
    logic signed [TEMP_W-1:0] shw_temperature;
    logic [HUM_W-1:0]         shw_humidity;
    logic [UV_W-1:0]          shw_uv;
    logic [PRESS_W-1:0]       shw_pressure;
  } result_t;

endpackage

>>> hw/rtl/escr_scale.sv
module escr_scale
  import escr_pkg::*;
(
  input  logic signed [TEMP_W-1:0] temperature_raw,
  input  logic [16:0]              pressure_pa,
  input  logic [19:0]              humidity_q10,
  input  logic [15:0]              light_count,
  output sample_t                  smp
);

  logic [34:0] press_prod;
  logic [18:0] light_x7;
  logic [38:0] uvm_prod;

  always_comb begin
    press_prod = {18'd0, pressure_pa} * {17'd0, PRESS_RECIP};
    light_x7   = {light_count, 3'd0} - {3'd0, light_count};
    uvm_prod   = {20'd0, light_x7} * {19'd0, UVM_RECIP};

    smp.temperature = temperature_raw;
    smp.humidity    = humidity_q10[17:10];
    smp.uv          = UV_W'({13'd0, light_count} * {16'd0, UV_SCALE});
    smp.uv_millions = uvm_prod[UVM_SHIFT +: UVM_W];
    smp.pressure    = press_prod[PRESS_SHIFT +: PQ_W];
  end

endmodule

>>> hw/rtl/escr_eval.sv
module escr_eval
  import escr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  cfg_t    cfg,
  input  logic    fire,
  input  logic    op,
  input  sample_t smp,
  output result_t res
);

  logic signed [TEMP_W-1:0] last_temperature;
  logic [HUM_W-1:0]         last_humidity;
  logic [PQ_W-1:0]          last_pressure;
  logic [RUN_W-1:0]         temp_run;
  logic [RUN_W-1:0]         hum_run;
  logic [RUN_W-1:0]         press_run;
  logic signed [TEMP_W-1:0] disp_temperature;
  logic [HUM_W-1:0]         disp_humidity;
  logic [UV_W-1:0]          disp_uv;
  logic [UVM_W-1:0]         disp_uvm;
  logic [PQ_W-1:0]          disp_pressure;

  logic [RUN_W-1:0]         temp_run_next;
  logic [RUN_W-1:0]         hum_run_next;
  logic [RUN_W-1:0]         press_run_next;
  logic signed [TEMP_W-1:0] disp_temperature_next;
  logic [HUM_W-1:0]         disp_humidity_next;
  logic [UV_W-1:0]          disp_uv_next;
  logic [UVM_W-1:0]         disp_uvm_next;
  logic [PQ_W-1:0]          disp_pressure_next;

  logic                   load_op;
  logic signed [TEMP_W:0] tdiff;
  logic [TEMP_W:0]        tabs;
  logic [UVM_W-1:0]       uvdiff;
  logic [FLAG_W-1:0]      flags;

  function automatic logic [RUN_W-1:0] bump(input logic [RUN_W-1:0] run);
    bump = (run == RUN_MAX) ? RUN_MAX : run + 1'b1;
  endfunction

  always_comb begin
    load_op = (op == OP_LOAD);

    temp_run_next  = (last_temperature == smp.temperature) ? bump(temp_run) : '0;
    hum_run_next   = (last_humidity == smp.humidity) ? bump(hum_run) : '0;
    press_run_next = (last_pressure == smp.pressure) ? bump(press_run) : '0;

    tdiff  = {disp_temperature[TEMP_W-1], disp_temperature}
           - {smp.temperature[TEMP_W-1], smp.temperature};
    tabs   = tdiff[TEMP_W] ? (TEMP_W+1)'(-tdiff) : tdiff;
    uvdiff = (disp_uvm > smp.uv_millions) ? disp_uvm - smp.uv_millions
                                          : smp.uv_millions - disp_uvm;

    flags = '0;
    if (op == OP_EVAL) begin
      flags[FLAG_TEMP]  = (temp_run_next >= cfg.temp_stable_need)
                        && (tabs > {1'b0, cfg.temp_deadband});
      flags[FLAG_HUM]   = (hum_run_next >= cfg.hum_stable_need)
                        && (disp_humidity != smp.humidity);
      flags[FLAG_UV]    = uvdiff > cfg.uv_deadband;
      flags[FLAG_PRESS] = (press_run_next >= cfg.press_stable_need)
                        && (disp_pressure != smp.pressure);
    end

    // load op copies everything, evaluate copies only flagged channels
    disp_temperature_next = (load_op || flags[FLAG_TEMP])  ? smp.temperature : disp_temperature;
    disp_humidity_next    = (load_op || flags[FLAG_HUM])   ? smp.humidity    : disp_humidity;
    disp_uv_next          = (load_op || flags[FLAG_UV])    ? smp.uv          : disp_uv;
    disp_uvm_next         = (load_op || flags[FLAG_UV])    ? smp.uv_millions : disp_uvm;
    disp_pressure_next    = (load_op || flags[FLAG_PRESS]) ? smp.pressure    : disp_pressure;

    res.flags           = flags;
    res.smp_temperature = smp.temperature;
    res.smp_humidity    = smp.humidity;
    res.smp_uv          = smp.uv;
    res.smp_pressure    = {{(PRESS_W-PQ_W){1'b0}}, smp.pressure};
    res.shw_temperature = disp_temperature_next;
    res.shw_humidity    = disp_humidity_next;
    res.shw_uv          = disp_uv_next;
    res.shw_pressure    = {{(PRESS_W-PQ_W){1'b0}}, disp_pressure_next};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_temperature <= '0;
      last_humidity    <= '0;
      last_pressure    <= '0;
      temp_run         <= '0;
      hum_run          <= '0;
      press_run        <= '0;
      disp_temperature <= '0;
      disp_humidity    <= '0;
      disp_uv          <= '0;
      disp_uvm         <= '0;
      disp_pressure    <= '0;
    end else if (fire) begin
      if (op == OP_EVAL) begin
        last_temperature <= smp.temperature;
        last_humidity    <= smp.humidity;
        last_pressure    <= smp.pressure;
        temp_run         <= temp_run_next;
        hum_run          <= hum_run_next;
        press_run        <= press_run_next;
      end
      disp_temperature <= disp_temperature_next;
      disp_humidity    <= disp_humidity_next;
      disp_uv          <= disp_uv_next;
      disp_uvm         <= disp_uvm_next;
      disp_pressure    <= disp_pressure_next;
    end
  end

endmodule

>>> hw/rtl/env_sensor_change_reporter.sv
// channel  direction  handshake            payload
// in       input      in_valid/in_ready    op, temperature_raw, pressure_pa,
//                                          humidity_q10, light_count
// out      output     out_valid/out_ready  notify, update_flags, sample_*, shown_*
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// one item per cycle sustained while out_ready stays high; on its way to the result
// an item passes the scaling multipliers ahead of the sample register and then the
// compare/update logic between the sample register and the result register
// rst (synchronous) clears config to defaults, all channel state and both valids
// a stalled result holds the sample register, which then lowers in_ready
// cfg_ready is always high; writes beyond the register list are dropped
module env_sensor_change_reporter
  import escr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,

  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      op,
  input  logic signed [TEMP_W-1:0]  temperature_raw,
  input  logic [16:0]               pressure_pa,
  input  logic [19:0]               humidity_q10,
  input  logic [15:0]               light_count,

  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      notify,
  output logic [FLAG_W-1:0]         update_flags,
  output logic signed [TEMP_W-1:0]  sample_temperature,
  output logic [HUM_W-1:0]          sample_humidity,
  output logic [UV_W-1:0]           sample_uv,
  output logic [PRESS_W-1:0]        sample_pressure,
  output logic signed [TEMP_W-1:0]  shown_temperature,
  output logic [HUM_W-1:0]          shown_humidity,
  output logic [UV_W-1:0]           shown_uv,
  output logic [PRESS_W-1:0]        shown_pressure,

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data
);

  cfg_t    cfg;
  sample_t scaled;
  sample_t smp;
  logic    smp_op;
  logic    smp_valid;
  logic    smp_fire;
  result_t res_comb;
  result_t res;

  // scaling sits in front of the sample register
  escr_scale u_scale (
    .temperature_raw (temperature_raw),
    .pressure_pa     (pressure_pa),
    .humidity_q10    (humidity_q10),
    .light_count     (light_count),
    .smp             (scaled)
  );

  // sample moves on when the result register is empty or being drained
  assign smp_fire  = smp_valid && (!out_valid || out_ready);
  assign in_ready  = !smp_valid || smp_fire;
  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_deadband     <= 16'd10;
      cfg.uv_deadband       <= 9'd4;
      cfg.temp_stable_need  <= 8'd1;
      cfg.hum_stable_need   <= 8'd1;
      cfg.press_stable_need <= 8'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TEMP_DEADBAND:     cfg.temp_deadband     <= cfg_data;
        CFG_UV_DEADBAND:       cfg.uv_deadband       <= cfg_data[8:0];
        CFG_TEMP_STABLE_NEED:  cfg.temp_stable_need  <= cfg_data[RUN_W-1:0];
        CFG_HUM_STABLE_NEED:   cfg.hum_stable_need   <= cfg_data[RUN_W-1:0];
        CFG_PRESS_STABLE_NEED: cfg.press_stable_need <= cfg_data[RUN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // sample register
  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (in_ready) begin
      smp_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      smp    <= scaled;
      smp_op <= op;
    end
  end

  // evaluation against the channel state, state advances on smp_fire
  escr_eval u_eval (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .fire (smp_fire),
    .op   (smp_op),
    .smp  (smp),
    .res  (res_comb)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (smp_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (smp_fire) begin
      res <= res_comb;
    end
  end

  assign notify             = |res.flags;
  assign update_flags       = res.flags;
  assign sample_temperature = res.smp_temperature;
  assign sample_humidity    = res.smp_humidity;
  assign sample_uv          = res.smp_uv;
  assign sample_pressure    = res.smp_pressure;
  assign shown_temperature  = res.shw_temperature;
  assign shown_humidity     = res.shw_humidity;
  assign shown_uv           = res.shw_uv;
  assign shown_pressure     = res.shw_pressure;

`ifndef SYNTHESIS
  // a stalled sample keeps its contents
  a_smp_hold: assert property (@(posedge clk) disable iff (rst)
    smp_valid && !smp_fire |=> smp_valid && $stable(smp) && $stable(smp_op))
    else $error("sample register changed while stalled");

  // an empty sample stage always takes input
  a_ready_empty: assert property (@(posedge clk) disable iff (rst)
    !smp_valid |-> in_ready)
    else $error("input stalled with empty sample stage");

  // an updated channel shows the sample value
  a_temp_copy: assert property (@(posedge clk) disable iff (rst)
    out_valid && update_flags[FLAG_TEMP] |-> shown_temperature == sample_temperature)
    else $error("temperature flagged but not copied");

  a_press_copy: assert property (@(posedge clk) disable iff (rst)
    out_valid && update_flags[FLAG_PRESS] |-> shown_pressure == sample_pressure)
    else $error("pressure flagged but not copied");

  // load op never raises flags and loads every shown value
  a_load_flags: assert property (@(posedge clk) disable iff (rst)
    smp_fire && (smp_op == OP_LOAD) |=> update_flags == '0 && shown_uv == sample_uv)
    else $error("load op produced flags or missed a copy");
`endif

endmodule

>>> tb/escr_report_checker.sv
module escr_report_checker
  import escr_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,

  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic                      op,
  input  logic signed [TEMP_W-1:0]  temperature_raw,
  input  logic [16:0]               pressure_pa,
  input  logic [19:0]               humidity_q10,
  input  logic [15:0]               light_count,

  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic                      notify,
  input  logic [FLAG_W-1:0]         update_flags,
  input  logic signed [TEMP_W-1:0]  sample_temperature,
  input  logic [HUM_W-1:0]          sample_humidity,
  input  logic [UV_W-1:0]           sample_uv,
  input  logic [PRESS_W-1:0]        sample_pressure,
  input  logic signed [TEMP_W-1:0]  shown_temperature,
  input  logic [HUM_W-1:0]          shown_humidity,
  input  logic [UV_W-1:0]           shown_uv,
  input  logic [PRESS_W-1:0]        shown_pressure,

  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_data,

  output int unsigned               fail_count,
  output logic                      busy
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic                     notify;
    logic [FLAG_W-1:0]        flags;
    logic signed [TEMP_W-1:0] smp_temperature;
    logic [HUM_W-1:0]         smp_humidity;
    logic [UV_W-1:0]          smp_uv;
    logic [PRESS_W-1:0]       smp_pressure;
    logic signed [TEMP_W-1:0] shw_temperature;
    logic [HUM_W-1:0]         shw_humidity;
    logic [UV_W-1:0]          shw_uv;
    logic [PRESS_W-1:0]       shw_pressure;
  } report_t;

  cfg_t cfg;

  logic signed [TEMP_W-1:0] last_temp, shw_temp;
  logic [HUM_W-1:0]         last_hum, shw_hum;
  logic [PRESS_W-1:0]       last_press, shw_press;
  logic [UV_W-1:0]          shw_uv;
  logic [RUN_W-1:0]         temp_run, hum_run, press_run;

  report_t     pending_reports[$];
  int unsigned errors;
  int unsigned n_in, n_out;

  assign fail_count = errors;
  assign busy = (n_in != n_out);

  function automatic logic [RUN_W-1:0] bump_run(input logic [RUN_W-1:0] r);
    return (r == RUN_MAX) ? r : r + 1'b1;
  endfunction

  task automatic compute_report(input logic op_i, input logic signed [TEMP_W-1:0] t_raw,
                                input logic [16:0] p_pa, input logic [19:0] h_q10,
                                input logic [15:0] l_cnt);
    report_t                  r;
    logic signed [TEMP_W-1:0] s_temp;
    logic [HUM_W-1:0]         s_hum;
    logic [UV_W-1:0]          s_uv;
    logic [PRESS_W-1:0]       s_press;
    logic [FLAG_W-1:0]        fl;
    int                       diff, ud, us;
    s_temp  = t_raw;
    s_press = PRESS_W'(p_pa / 17'd100);
    s_hum   = HUM_W'(h_q10 / 20'd1024);
    s_uv    = UV_W'(l_cnt) * UV_W'(7000);
    fl      = '0;
    if (op_i == OP_LOAD) begin
      shw_temp  = s_temp;
      shw_hum   = s_hum;
      shw_uv    = s_uv;
      shw_press = s_press;
    end else begin
      if (last_temp != s_temp) begin
        temp_run  = '0;
        last_temp = s_temp;
      end else begin
        temp_run = bump_run(temp_run);
      end
      diff = int'(shw_temp) - int'(last_temp);
      if (diff < 0) diff = -diff;
      if (temp_run >= cfg.temp_stable_need && diff > int'(cfg.temp_deadband)) begin
        shw_temp = last_temp;
        fl[FLAG_TEMP] = 1'b1;
      end

      if (last_hum != s_hum) begin
        hum_run  = '0;
        last_hum = s_hum;
      end else begin
        hum_run = bump_run(hum_run);
      end
      if (hum_run >= cfg.hum_stable_need && shw_hum != last_hum) begin
        shw_hum = last_hum;
        fl[FLAG_HUM] = 1'b1;
      end

      // uv has no run counter, only whole millions are compared
      ud = int'(shw_uv / UV_W'(1000000));
      us = int'(s_uv / UV_W'(1000000));
      if ((ud > us ? ud - us : us - ud) > int'(cfg.uv_deadband)) begin
        shw_uv = s_uv;
        fl[FLAG_UV] = 1'b1;
      end

      if (last_press != s_press) begin
        press_run  = '0;
        last_press = s_press;
      end else begin
        press_run = bump_run(press_run);
      end
      if (press_run >= cfg.press_stable_need && shw_press != last_press) begin
        shw_press = last_press;
        fl[FLAG_PRESS] = 1'b1;
      end
    end
    r.notify          = (fl != '0);
    r.flags           = fl;
    r.smp_temperature = s_temp;
    r.smp_humidity    = s_hum;
    r.smp_uv          = s_uv;
    r.smp_pressure    = s_press;
    r.shw_temperature = shw_temp;
    r.shw_humidity    = shw_hum;
    r.shw_uv          = shw_uv;
    r.shw_pressure    = shw_press;
    pending_reports.push_back(r);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    report_t w;
    if (rst) begin
      cfg.temp_deadband     = 16'd10;
      cfg.uv_deadband       = 9'd4;
      cfg.temp_stable_need  = 8'd1;
      cfg.hum_stable_need   = 8'd1;
      cfg.press_stable_need = 8'd10;
      last_temp  = '0;
      last_hum   = '0;
      last_press = '0;
      temp_run   = '0;
      hum_run    = '0;
      press_run  = '0;
      shw_temp   = '0;
      shw_hum    = '0;
      shw_uv     = '0;
      shw_press  = '0;
      pending_reports.delete();
      errors = 0;
      n_in  <= 0;
      n_out <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEMP_DEADBAND:     cfg.temp_deadband     = cfg_data;
          CFG_UV_DEADBAND:       cfg.uv_deadband       = cfg_data[8:0];
          CFG_TEMP_STABLE_NEED:  cfg.temp_stable_need  = cfg_data[RUN_W-1:0];
          CFG_HUM_STABLE_NEED:   cfg.hum_stable_need   = cfg_data[RUN_W-1:0];
          CFG_PRESS_STABLE_NEED: cfg.press_stable_need = cfg_data[RUN_W-1:0];
          default: ;
        endcase
      end
      // result side first so a stray result never takes a fresh prediction
      if (out_valid && out_ready) begin
        n_out <= n_out + 1;
        if (pending_reports.size() == 0) begin
          errors++;
          $display("%0t: result transfer with nothing expected", $time);
        end else begin
          w = pending_reports.pop_front();
          check_field("notify", w.notify, notify);
          check_field("update_flags", w.flags, update_flags);
          check_field("sample_temperature", w.smp_temperature, sample_temperature);
          check_field("sample_humidity", w.smp_humidity, sample_humidity);
          check_field("sample_uv", w.smp_uv, sample_uv);
          check_field("sample_pressure", w.smp_pressure, sample_pressure);
          check_field("shown_temperature", w.shw_temperature, shown_temperature);
          check_field("shown_humidity", w.shw_humidity, shown_humidity);
          check_field("shown_uv", w.shw_uv, shown_uv);
          check_field("shown_pressure", w.shw_pressure, shown_pressure);
        end
      end
      if (in_valid && in_ready) begin
        n_in <= n_in + 1;
        compute_report(op, temperature_raw, pressure_pa, humidity_q10, light_count);
      end
    end
  end

endmodule

>>> tb/env_sensor_change_reporter_tb.sv
module env_sensor_change_reporter_tb
  import escr_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  // cycles without any transfer before the run is declared hung; the longest
  // legitimate quiet stretch is the receiver hold-off plus one idle gap
  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 160;
  localparam int LATENCY     = 2;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     op = OP_EVAL;
  logic signed [TEMP_W-1:0] temperature_raw = '0;
  logic [16:0]              pressure_pa = '0;
  logic [19:0]              humidity_q10 = '0;
  logic [15:0]              light_count = '0;

  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     notify;
  logic [FLAG_W-1:0]        update_flags;
  logic signed [TEMP_W-1:0] sample_temperature;
  logic [HUM_W-1:0]         sample_humidity;
  logic [UV_W-1:0]          sample_uv;
  logic [PRESS_W-1:0]       sample_pressure;
  logic signed [TEMP_W-1:0] shown_temperature;
  logic [HUM_W-1:0]         shown_humidity;
  logic [UV_W-1:0]          shown_uv;
  logic [PRESS_W-1:0]       shown_pressure;

  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  int unsigned fail_count;
  logic        busy;
  int unsigned quiet_cycles;

  // burst counters: while non-zero that side runs with no idle cycles
  int tx_burst = 0;
  int rx_burst = 0;

  // sample generator state: a segment holds one base sample per channel so
  // that the repeat counters climb and the stability paths get exercised
  logic signed [TEMP_W-1:0] base_temp = '0;
  int                       base_hpa = 0;
  int                       base_pct = 0;
  logic [15:0]              base_light = '0;
  int                       seg_left = 0;
  bit                       seg_steady = 1'b0;

  always #5 clk = ~clk;

  env_sensor_change_reporter dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .op                 (op),
    .temperature_raw    (temperature_raw),
    .pressure_pa        (pressure_pa),
    .humidity_q10       (humidity_q10),
    .light_count        (light_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .notify             (notify),
    .update_flags       (update_flags),
    .sample_temperature (sample_temperature),
    .sample_humidity    (sample_humidity),
    .sample_uv          (sample_uv),
    .sample_pressure    (sample_pressure),
    .shown_temperature  (shown_temperature),
    .shown_humidity     (shown_humidity),
    .shown_uv           (shown_uv),
    .shown_pressure     (shown_pressure),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data)
  );

  escr_report_checker checker_i (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .op                 (op),
    .temperature_raw    (temperature_raw),
    .pressure_pa        (pressure_pa),
    .humidity_q10       (humidity_q10),
    .light_count        (light_count),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .notify             (notify),
    .update_flags       (update_flags),
    .sample_temperature (sample_temperature),
    .sample_humidity    (sample_humidity),
    .sample_uv          (sample_uv),
    .sample_pressure    (sample_pressure),
    .shown_temperature  (shown_temperature),
    .shown_humidity     (shown_humidity),
    .shown_uv           (shown_uv),
    .shown_pressure     (shown_pressure),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .fail_count         (fail_count),
    .busy               (busy)
  );

  // watchdog: any transfer on any channel counts as progress
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  // idle gap per transfer, drawn at random, with occasional gap-free bursts
  task automatic draw_gap(inout int burst_left, output int gap);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else if ($urandom_range(0, 15) == 0) begin
      burst_left = $urandom_range(16, 48);
      gap = 0;
    end else begin
      gap = $urandom_range(0, 11);
    end
  endtask

  // one input transfer; valid stays high across back-to-back items
  task automatic send_item(input logic op_i, input logic signed [TEMP_W-1:0] t,
                           input logic [16:0] p, input logic [19:0] h,
                           input logic [15:0] l);
    int gap;
    draw_gap(tx_burst, gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    op              <= op_i;
    temperature_raw <= t;
    pressure_pa     <= p;
    humidity_q10    <= h;
    light_count     <= l;
    do @(posedge clk); while (!in_ready);
  endtask

  // drop valid and wait until every predicted result has been transferred
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (busy);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // full register set plus one write past the end of the list, which must be dropped
  task automatic set_config(input logic [15:0] tdb, input logic [15:0] udb,
                            input logic [15:0] tneed, input logic [15:0] hneed,
                            input logic [15:0] pneed);
    wait_drained();
    write_reg(CFG_TEMP_DEADBAND, tdb);
    write_reg(CFG_UV_DEADBAND, udb);
    write_reg(CFG_TEMP_STABLE_NEED, tneed);
    write_reg(CFG_HUM_STABLE_NEED, hneed);
    write_reg(CFG_PRESS_STABLE_NEED, pneed);
    write_reg(CFG_IDX_W'(CFG_PRESS_STABLE_NEED) + CFG_IDX_W'($urandom_range(1, 3)),
              CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  // new base values; each channel but light keeps its value, steps a little or jumps
  task automatic start_segment(input bit force_long);
    int step;
    int v;
    if (force_long) begin
      seg_left = $urandom_range(270, 320);
    end else if ($urandom_range(0, 11) == 0) begin
      seg_left = $urandom_range(60, 300);
    end else begin
      seg_left = $urandom_range(1, 24);
    end
    seg_steady = (seg_left >= 60);

    if ($urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 1) == 0) begin
        step = $urandom_range(0, 80);
        v = int'(base_temp) + step - 40;
        base_temp = TEMP_W'(v);
      end else begin
        base_temp = TEMP_W'($urandom);
      end
    end
    if ($urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 1) == 0) begin
        step = $urandom_range(0, 20);
        v = base_hpa + step - 10;
        base_hpa = (v < 0) ? 0 : (v > 1310) ? 1310 : v;
      end else begin
        base_hpa = $urandom_range(0, 1310);
      end
    end
    if ($urandom_range(0, 2) != 0) begin
      if ($urandom_range(0, 1) == 0) begin
        step = $urandom_range(0, 6);
        v = base_pct + step - 3;
        base_pct = (v < 0) ? 0 : (v > 1023) ? 1023 : v;
      end else begin
        base_pct = $urandom_range(0, 1023);
      end
    end
    // low counts keep uv near the deadband, a full draw reaches the top bits
    base_light = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 1200)) : 16'($urandom);
  endtask

  task automatic run_random(input int count, input bit force_long);
    logic                     op_i;
    logic signed [TEMP_W-1:0] t;
    logic [16:0]              p;
    logic [19:0]              h;
    logic [15:0]              l;
    int                       pv;
    for (int i = 0; i < count; i++) begin
      if (seg_left == 0 || (force_long && i == 0)) start_segment(force_long && i == 0);
      seg_left--;
      if (!seg_steady && $urandom_range(0, 9) == 0) begin
        // noise: every field drawn over its full width
        send_item(1'($urandom), TEMP_W'($urandom), 17'($urandom), 20'($urandom),
                  16'($urandom));
      end else begin
        op_i = ($urandom_range(0, 23) == 0) ? OP_LOAD : OP_EVAL;
        t = base_temp;
        // raw jitter that stays inside one scaled step keeps the run alive
        pv = base_hpa * 100 + int'($urandom_range(0, 99));
        if (pv > 131071) pv = 131071;
        p = 17'(pv);
        h = 20'(base_pct * 1024 + int'($urandom_range(0, 1023)));
        l = ($urandom_range(0, 1) == 0) ? base_light
                                        : base_light + 16'($urandom_range(0, 400)) - 16'd200;
        if (!seg_steady) begin
          // an occasional glitch breaks one channel's run
          if ($urandom_range(0, 15) == 0) t = TEMP_W'($urandom);
          if ($urandom_range(0, 15) == 0) p = 17'($urandom);
          if ($urandom_range(0, 15) == 0) h = 20'($urandom);
        end
        send_item(op_i, t, p, h, l);
      end
    end
  endtask

  // receiver: random back-pressure, with two long hold-offs so the block fills
  initial begin
    int gap;
    int n_rx;
    n_rx = 0;
    @(negedge rst);
    forever begin
      draw_gap(rx_burst, gap);
      if (n_rx == 300 || n_rx == 1000) gap = HOLD_CYCLES;
      if (gap != 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      n_rx++;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed items under the reset configuration
    send_item(OP_EVAL, 16'h0000, 17'd0, 20'd0, 16'd0);
    // largest values on every input, then repeated so temperature and humidity settle
    send_item(OP_EVAL, 16'h7FFF, 17'h1FFFF, 20'hFFFFF, 16'hFFFF);
    send_item(OP_EVAL, 16'h7FFF, 17'h1FFFF, 20'hFFFFF, 16'hFFFF);
    send_item(OP_EVAL, 16'h8000, 17'd0, 20'd0, 16'd0);
    send_item(OP_EVAL, 16'h8000, 17'd0, 20'd0, 16'd0);
    // load op with humidity just under the 8-bit wrap
    send_item(OP_LOAD, 16'h7FFF, 17'h1FFFF, 20'd262143, 16'hFFFF);
    send_item(OP_LOAD, 16'sd100, 17'd10000, 20'd51200, 16'd0);
    // temperature exactly on the deadband, uv exactly on its deadband
    send_item(OP_EVAL, 16'sd110, 17'd10000, 20'd51200, 16'd572);
    send_item(OP_EVAL, 16'sd110, 17'd10099, 20'd52223, 16'd572);
    // one past both deadbands
    send_item(OP_EVAL, 16'sd111, 17'd10050, 20'd51200, 16'd715);
    send_item(OP_EVAL, 16'sd111, 17'd10050, 20'd51200, 16'd715);
    // humidity of 256 percent wraps to zero
    send_item(OP_EVAL, -16'sd11, 17'd0, 20'd262144, 16'd0);
    send_item(OP_EVAL, -16'sd11, 17'd0, 20'd262144, 16'd0);
    send_item(OP_LOAD, 16'h0000, 17'd0, 20'd0, 16'd0);
    send_item(OP_EVAL, 16'h7FFF, 17'd0, 20'd0, 16'd0);
    send_item(OP_EVAL, 16'h7FFF, 17'd0, 20'd0, 16'd0);
    // widest signed difference between shown and sample
    send_item(OP_LOAD, 16'h8000, 17'd0, 20'd0, 16'd0);
    send_item(OP_EVAL, 16'h7FFF, 17'd0, 20'd0, 16'd0);
    run_random(260, 1'b0);

    // zero deadbands and zero needs: stability always holds
    set_config(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_random(260, 1'b0);

    // all ones: upper data bits must be masked, needs of 255 reach saturation
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(360, 1'b1);

    // arbitrary data over the whole write width
    set_config(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(260, 1'b0);

    // moderate settings where updates are frequent
    set_config(16'($urandom_range(0, 200)), 16'($urandom_range(0, 20)),
               16'($urandom_range(0, 12)), 16'($urandom_range(0, 12)),
               16'($urandom_range(0, 12)));
    run_random(260, 1'b0);

    set_config(16'($urandom_range(0, 30)), 16'($urandom_range(0, 8)),
               16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)),
               16'($urandom_range(1, 3)));
    run_random(250, 1'b0);

    wait_drained();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
hw/rtl/escr_pkg.sv
hw/rtl/escr_scale.sv
hw/rtl/escr_eval.sv
hw/rtl/env_sensor_change_reporter.sv
tb/escr_report_checker.sv
tb/env_sensor_change_reporter_tb.sv
